/* rtl/assert_macros.svh */
// assertion macros used by the evaluator top file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* rtl/ttce_pkg.sv */
// shared types and constants for the track threat confidence evaluator
// no dependencies
package ttce_pkg;
  localparam int TRACK_SLOTS = 64;
  localparam int SLOT_W = $clog2(TRACK_SLOTS);
  localparam int CNT_W = $clog2(TRACK_SLOTS + 1);

  localparam logic [16:0] CONF_ONE = 17'd65536;
  localparam logic [16:0] CONF_HIT_STEP = 17'd22938;
  localparam logic [16:0] CONF_DECAY_MUL = 17'd39322;
  localparam logic [16:0] CONF_CONFIRMED_FLOOR = 17'd45875;
  localparam logic [16:0] CONF_TENTATIVE_CEIL = 17'd19661;

  localparam logic [1:0] ST_TENTATIVE = 2'd0;
  localparam logic [1:0] ST_CONFIRMED = 2'd1;
  localparam logic [1:0] ST_LOST = 2'd2;

  localparam logic [1:0] MS_FOUND = 2'd1;

  localparam logic [7:0] CLS_UNKNOWN = 8'd0;
  localparam logic [7:0] CLS_HIGH_TARGET = 8'd1;
  localparam logic [7:0] CLS_HIGH_FIGHTER = 8'd2;
  localparam logic [7:0] CLS_LOW = 8'd3;

  localparam logic [1:0] CFG_MIN_PROB = 2'd0;
  localparam logic [1:0] CFG_MAX_DIST = 2'd1;
  localparam logic [1:0] CFG_AGGR_CONF = 2'd2;

  localparam logic CMD_REPORT = 1'b0;

  // classified item handed from front to back
  typedef struct packed {
    logic       is_report;
    logic       frame_start;
    logic [63:0] key;
    logic       jam;
    logic [1:0] status;
    logic       meas;
    logic [7:0] cls;
    logic [4:0] score;
  } job_t;

  typedef struct packed {
    logic [7:0]  class_code;
    logic [4:0]  threat_level;
    logic [16:0] confidence;
    logic        aggressive_allowed;
    logic        reduce_power;
    logic        jamming_signal;
    logic        recon_platform;
    logic        table_overflow;
  } res_t;
endpackage

/* rtl/ttce_ram.sv */
// generic single port ram with registered read
// no dependencies
module ttce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/ttce_front.sv */
// front end: threat score and classification of one item
// depends on ttce_pkg
module ttce_front import ttce_pkg::*; (
  input  logic        command,
  input  logic        frame_start,
  input  logic [63:0] assoc_key,
  input  logic [15:0] speed,
  input  logic [15:0] rcs,
  input  logic        jamming,
  input  logic [1:0]  track_status,
  input  logic        has_measurement,
  input  logic [1:0]  match_status,
  input  logic [7:0]  match_type,
  input  logic [16:0] match_probability,
  input  logic [15:0] match_distance,
  input  logic [16:0] min_prob,
  input  logic [15:0] max_dist,
  output job_t        job
);
  logic [4:0] s;
  logic       match_ok;
  always_comb begin
    s = 5'd0;
    if (speed > 16'd4800) s = s + 5'd8;
    else if (speed > 16'd1920) s = s + 5'd4;
    if (rcs > 16'd768) s = s + 5'd4;
    else if (rcs > 16'd307) s = s + 5'd2;
    if (jamming) s = s + 5'd4;
    if (track_status == ST_CONFIRMED) s = s + 5'd1;
    match_ok = (match_status == MS_FOUND) && (match_type != CLS_UNKNOWN) &&
               (match_probability >= min_prob) && (match_distance <= max_dist);
    job.is_report = (command == CMD_REPORT);
    job.frame_start = frame_start;
    job.key = assoc_key;
    job.jam = jamming;
    job.status = track_status;
    job.meas = has_measurement;
    job.score = job.is_report ? s : 5'd0;
    if (!job.is_report) job.cls = CLS_UNKNOWN;
    else if (match_ok) job.cls = match_type;
    else if (s >= 5'd8) job.cls = CLS_HIGH_TARGET;
    else if (s >= 5'd4) job.cls = CLS_LOW;
    else job.cls = CLS_UNKNOWN;
  end
endmodule

/* rtl/ttce_fifo.sv */
// two entry queue between front and back
// depends on ttce_pkg
module ttce_fifo import ttce_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t rdata
);
  job_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = q_r[rp_r];
  always_ff @(posedge clk) begin
    if (push && !full) begin
      q_r[wp_r] <= wdata;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end
endmodule

/* rtl/ttce_back.sv */
// back end: slot search, confidence update, frame flags, result register
// depends on ttce_pkg and ttce_ram
module ttce_back import ttce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_take,
  input  logic [16:0] aggr_conf,
  output logic        res_valid,
  output res_t        res,
  input  logic        res_take
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]        st_r, st_nxt;
  logic [SLOT_W-1:0] idx_r;
  logic [CNT_W-1:0]  fill_r;
  logic              hit_r;
  logic              ovf_r;
  logic [16:0]       c_r;
  logic [33:0]       prod_r;
  logic [2:0]        flags_r;
  logic              rv_r;
  res_t              res_r;
  logic              key_we, conf_we;
  logic [SLOT_W-1:0] addr;
  logic [63:0]       key_rd;
  logic [16:0]       conf_rd, c_fin, c_new;
  logic [17:0]       c_sum;
  logic              aggr;
  logic [2:0]        fl;

  // slots fill from zero upward and are never freed, so a fill count stands
  // in for the valid bits
  ttce_ram #(.WIDTH(64), .DEPTH(TRACK_SLOTS)) u_key (
    .clk(clk), .we(key_we), .addr(addr), .wdata(job.key), .rdata(key_rd));
  ttce_ram #(.WIDTH(17), .DEPTH(TRACK_SLOTS)) u_conf (
    .clk(clk), .we(conf_we), .addr(addr), .wdata(c_fin), .rdata(conf_rd));

  assign addr = idx_r;
  assign res_valid = rv_r;
  assign res = res_r;
  assign job_take = (st_r == S_DONE) && !rv_r;

  always_comb begin
    c_sum = {1'b0, c_r} + {1'b0, CONF_HIT_STEP};
    if (job.meas) c_new = (c_sum > {1'b0, CONF_ONE}) ? CONF_ONE : c_sum[16:0];
    else c_new = prod_r[32:16];
    if (job.status == ST_CONFIRMED && c_new < CONF_CONFIRMED_FLOOR)
      c_new = CONF_CONFIRMED_FLOOR;
    if (job.status == ST_TENTATIVE && !job.meas && c_new > CONF_TENTATIVE_CEIL)
      c_new = CONF_TENTATIVE_CEIL;
    if (job.status == ST_LOST) c_new = {1'b0, c_new[16:1]};
    c_fin = c_new;
    aggr = (job.status != ST_LOST) && (c_fin >= aggr_conf) &&
           (job.meas || job.status == ST_CONFIRMED);
    fl = job.frame_start ? 3'd0 : flags_r;
    if (job.is_report) begin
      if (job.cls == CLS_HIGH_TARGET || job.cls == CLS_HIGH_FIGHTER) begin
        fl[2] = 1'b1;
        if (aggr) fl[0] = 1'b1;
      end
      if (aggr && job.jam) fl[1] = 1'b1;
    end
    key_we = (st_r == S_MUL) && !hit_r && ({1'b0, idx_r} == fill_r) &&
             (fill_r < CNT_W'(TRACK_SLOTS));
    conf_we = (st_r == S_MUL) && (hit_r || key_we);
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (job_valid) st_nxt = job.is_report ? ((fill_r == '0) ? S_CALC : S_SCAN)
                                                   : S_DONE;
      S_SCAN: st_nxt = S_CMP;
      S_CMP: begin
        if (key_rd == job.key) st_nxt = S_CALC;
        else if ({1'b0, idx_r} + CNT_W'(1) >= fill_r) st_nxt = S_CALC;
        else st_nxt = S_SCAN;
      end
      S_CALC: st_nxt = S_MUL;
      S_MUL: st_nxt = S_DONE;
      S_DONE: if (!rv_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        idx_r <= '0;
        hit_r <= 1'b0;
        c_r <= '0;
      end
      S_CMP: begin
        if (key_rd == job.key) begin
          hit_r <= 1'b1;
          c_r <= conf_rd;
        end else if ({1'b0, idx_r} + CNT_W'(1) >= fill_r) begin
          idx_r <= fill_r[SLOT_W-1:0];
        end else begin
          idx_r <= idx_r + SLOT_W'(1);
        end
      end
      S_CALC: prod_r <= c_r * CONF_DECAY_MUL;
      // new key with no free slot left
      S_MUL: ovf_r <= !hit_r && !key_we;
      default: ;
    endcase
    // the result register only changes once the previous result is gone
    if (job_take) begin
      res_r.class_code <= job.cls;
      res_r.threat_level <= job.score;
      res_r.reduce_power <= fl[0];
      res_r.jamming_signal <= fl[1];
      res_r.recon_platform <= fl[2];
      if (job.is_report) begin
        res_r.confidence <= c_fin;
        res_r.aggressive_allowed <= aggr;
        res_r.table_overflow <= ovf_r;
      end else begin
        res_r.confidence <= '0;
        res_r.aggressive_allowed <= 1'b0;
        res_r.table_overflow <= 1'b0;
      end
    end
    if (!rst_n) begin
      st_r <= S_IDLE;
      fill_r <= '0;
      flags_r <= 3'd0;
      rv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (key_we) fill_r <= fill_r + CNT_W'(1);
      if (job_take) begin
        flags_r <= fl;
        rv_r <= 1'b1;
      end else if (res_take) begin
        rv_r <= 1'b0;
      end
    end
  end
endmodule

/* rtl/track_threat_confidence_evaluator.sv */
// track threat confidence evaluator: scores and classifies radar track reports,
// tracks per-key confidence in a 64 slot table and keeps sticky frame flags.
// the back end searches the keys stored so far (at most 64) one after another until
// a match, reading a slot of the slot memory in its scan state and comparing it in
// its compare state, then runs its calc, mul and done states. the front
// end classifies in the accept cycle and a two entry queue lets it run ahead.
// results wait in an output register so the next item can enter meanwhile.
// depends on ttce_pkg, ttce_front, ttce_fifo, ttce_back and assert_macros.svh
`include "assert_macros.svh"
module track_threat_confidence_evaluator import ttce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        in_command,
  input  logic        in_frame_start,
  input  logic [63:0] in_assoc_key,
  input  logic [15:0] in_speed,
  input  logic [15:0] in_rcs,
  input  logic        in_jamming,
  input  logic [1:0]  in_track_status,
  input  logic        in_has_measurement,
  input  logic [1:0]  in_match_status,
  input  logic [7:0]  in_match_type,
  input  logic [16:0] in_match_probability,
  input  logic [15:0] in_match_distance,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_class_code,
  output logic [4:0]  out_threat_level,
  output logic [16:0] out_confidence,
  output logic        out_aggressive_allowed,
  output logic        out_reduce_power,
  output logic        out_jamming_signal,
  output logic        out_recon_platform,
  output logic        out_table_overflow
);
  // configuration registers
  logic [16:0] min_prob_r;
  logic [15:0] max_dist_r;
  logic [16:0] aggr_conf_r;
  job_t        fjob, qjob;
  logic        q_empty, take, rv;
  res_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_prob_r <= 17'd36045;
      max_dist_r <= 16'd460;
      aggr_conf_r <= 17'd36045;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_PROB: min_prob_r <= cfg_data;
        CFG_MAX_DIST: max_dist_r <= cfg_data[15:0];
        CFG_AGGR_CONF: aggr_conf_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: classify in the accept cycle
  ttce_front u_front (
    .command(in_command), .frame_start(in_frame_start), .assoc_key(in_assoc_key),
    .speed(in_speed), .rcs(in_rcs), .jamming(in_jamming),
    .track_status(in_track_status), .has_measurement(in_has_measurement),
    .match_status(in_match_status), .match_type(in_match_type),
    .match_probability(in_match_probability), .match_distance(in_match_distance),
    .min_prob(min_prob_r), .max_dist(max_dist_r), .job(fjob));

  // queue decouples the front from the slow table walk
  ttce_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(fjob), .full(full),
    .pop(take), .empty(q_empty), .rdata(qjob));

  // back: table search, update, flags, result register
  ttce_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(!q_empty), .job(qjob), .job_take(take),
    .aggr_conf(aggr_conf_r), .res_valid(rv), .res(res), .res_take(pop));

  assign empty = !rv;
  assign out_class_code = res.class_code;
  assign out_threat_level = res.threat_level;
  assign out_confidence = res.confidence;
  assign out_aggressive_allowed = res.aggressive_allowed;
  assign out_reduce_power = res.reduce_power;
  assign out_jamming_signal = res.jamming_signal;
  assign out_recon_platform = res.recon_platform;
  assign out_table_overflow = res.table_overflow;

  // a job only leaves the queue when one is there
  `ASSERT_NEVER(a_take_empty, clk, rst_n, take && q_empty)
  // confidence never exceeds one
  `ASSERT_NEVER(a_conf_range, clk, rst_n, rv && (res.confidence > CONF_ONE))
  // a result is only produced when the previous one was taken
  `ASSERT_CLK(a_no_overwrite, clk, rst_n, take |-> !rv)
endmodule

/* test/tb_track_threat_confidence_evaluator.sv */
// testbench for track_threat_confidence_evaluator: directed and random track reports
// checked against a behavioral model of scoring, classification and the track table
// depends on ttce_pkg and the evaluator rtl
`timescale 1ns / 1ps
module tb_track_threat_confidence_evaluator;
  import ttce_pkg::*;

  localparam int DRAIN_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic        command;
    logic        frame_start;
    logic [63:0] key;
    logic [15:0] speed;
    logic [15:0] rcs;
    logic        jam;
    logic [1:0]  status;
    logic        meas;
    logic [1:0]  mstat;
    logic [7:0]  mtype;
    logic [16:0] mprob;
    logic [15:0] mdist;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic        in_command = 1'b0;
  logic        in_frame_start = 1'b0;
  logic [63:0] in_assoc_key = '0;
  logic [15:0] in_speed = '0;
  logic [15:0] in_rcs = '0;
  logic        in_jamming = 1'b0;
  logic [1:0]  in_track_status = '0;
  logic        in_has_measurement = 1'b0;
  logic [1:0]  in_match_status = '0;
  logic [7:0]  in_match_type = '0;
  logic [16:0] in_match_probability = '0;
  logic [15:0] in_match_distance = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_class_code;
  logic [4:0]  out_threat_level;
  logic [16:0] out_confidence;
  logic        out_aggressive_allowed;
  logic        out_reduce_power;
  logic        out_jamming_signal;
  logic        out_recon_platform;
  logic        out_table_overflow;

  track_threat_confidence_evaluator i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state: track table, sticky frame flags and register copies
  logic [63:0] track_keys [TRACK_SLOTS];
  logic [16:0] track_conf [TRACK_SLOTS];
  logic        track_used [TRACK_SLOTS];
  logic        flag_reduce, flag_jam, flag_recon;
  logic [16:0] min_prob_reg = 17'd36045;
  logic [15:0] max_dist_reg = 16'd460;
  logic [16:0] aggr_conf_reg = 17'd36045;

  res_t        expected_results [$];
  logic [63:0] key_pool [$];
  int          mismatches = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;

  // score in quarter units
  function automatic logic [4:0] threat_quarters(report_t r);
    logic [4:0] s;
    s = 5'd0;
    if (r.speed > 16'd4800) s += 5'd8; else if (r.speed > 16'd1920) s += 5'd4;
    if (r.rcs > 16'd768) s += 5'd4; else if (r.rcs > 16'd307) s += 5'd2;
    if (r.jam) s += 5'd4;
    if (r.status == ST_CONFIRMED) s += 5'd1;
    return s;
  endfunction

  function automatic logic [16:0] next_conf(logic [16:0] c, report_t r);
    logic [33:0] prod;
    logic [17:0] sum;
    if (r.meas) begin
      sum = {1'b0, c} + {1'b0, CONF_HIT_STEP};
      c = (sum > {1'b0, CONF_ONE}) ? CONF_ONE : sum[16:0];
    end else begin
      prod = c * CONF_DECAY_MUL;
      c = prod[32:16];
    end
    if (r.status == ST_CONFIRMED && c < CONF_CONFIRMED_FLOOR) c = CONF_CONFIRMED_FLOOR;
    if (r.status == ST_TENTATIVE && !r.meas && c > CONF_TENTATIVE_CEIL)
      c = CONF_TENTATIVE_CEIL;
    if (r.status == ST_LOST) c = c >> 1;
    return c;
  endfunction

  // advances the model by one accepted item and returns the result it causes
  function automatic res_t evaluate_report(report_t r);
    res_t o;
    int   hit, free_idx;
    logic high;
    o = '0;
    hit = -1;
    free_idx = -1;
    if (r.frame_start) {flag_reduce, flag_jam, flag_recon} = 3'b000;
    if (r.command == CMD_REPORT) begin
      o.threat_level = threat_quarters(r);
      if (r.mstat == MS_FOUND && r.mtype != CLS_UNKNOWN && r.mprob >= min_prob_reg &&
          r.mdist <= max_dist_reg)
        o.class_code = r.mtype;
      else if (o.threat_level >= 5'd8) o.class_code = CLS_HIGH_TARGET;
      else if (o.threat_level >= 5'd4) o.class_code = CLS_LOW;
      else o.class_code = CLS_UNKNOWN;
      high = (o.class_code == CLS_HIGH_TARGET || o.class_code == CLS_HIGH_FIGHTER);
      if (high) flag_recon = 1'b1;
      for (int i = 0; i < TRACK_SLOTS; i++) begin
        if (track_used[i]) begin
          if (hit < 0 && track_keys[i] == r.key) hit = i;
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      o.confidence = next_conf(hit >= 0 ? track_conf[hit] : 17'd0, r);
      if (hit >= 0) begin
        track_conf[hit] = o.confidence;
      end else if (free_idx >= 0) begin
        track_used[free_idx] = 1'b1;
        track_keys[free_idx] = r.key;
        track_conf[free_idx] = o.confidence;
      end else begin
        o.table_overflow = 1'b1;
      end
      o.aggressive_allowed = (r.status != ST_LOST && o.confidence >= aggr_conf_reg &&
                              (r.meas || r.status == ST_CONFIRMED));
      if (o.aggressive_allowed && high) flag_reduce = 1'b1;
      if (o.aggressive_allowed && r.jam) flag_jam = 1'b1;
    end
    o.reduce_power = flag_reduce;
    o.jamming_signal = flag_jam;
    o.recon_platform = flag_recon;
    return o;
  endfunction

  // one item through the input queue; the sender runs in bursts with random gaps
  task automatic send_item(report_t r);
    int gap;
    @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    in_command <= r.command;
    in_frame_start <= r.frame_start;
    in_assoc_key <= r.key;
    in_speed <= r.speed;
    in_rcs <= r.rcs;
    in_jamming <= r.jam;
    in_track_status <= r.status;
    in_has_measurement <= r.meas;
    in_match_status <= r.mstat;
    in_match_type <= r.mtype;
    in_match_probability <= r.mprob;
    in_match_distance <= r.mdist;
    // full only moves at the rising edge, so its value at the falling edge holds for the next one
    do @(negedge clk); while (full);
    expected_results.push_back(evaluate_report(r));
  endtask

  // stop sending, wait for every expected item, then let the back end settle
  task automatic drain();
    @(posedge clk);
    push <= 1'b0;
    burst_left = 0;
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MIN_PROB:  min_prob_reg = value;
      CFG_MAX_DIST:  max_dist_reg = value[15:0];
      CFG_AGGR_CONF: aggr_conf_reg = value;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_near(logic [15:0] a, logic [15:0] b);
    case ($urandom_range(0, 3))
      0: return 16'(a + $urandom_range(0, 2) - 1);
      1: return 16'(b + $urandom_range(0, 2) - 1);
      2: return 16'($urandom_range(0, 6000));
      default: return 16'($urandom);
    endcase
  endfunction

  // well formed report with random content, occasional noise in the status and match fields
  function automatic report_t random_report(logic [63:0] key);
    report_t r;
    r.command = ($urandom_range(0, 19) == 0);
    r.frame_start = ($urandom_range(0, 7) == 0);
    r.key = key;
    r.speed = pick_near(16'd4800, 16'd1920);
    r.rcs = pick_near(16'd768, 16'd307);
    r.jam = 1'($urandom_range(0, 1));
    r.status = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    r.meas = ($urandom_range(0, 3) != 0);
    r.mstat = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    r.mtype = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: r.mprob = 17'(min_prob_reg + $urandom_range(0, 2) - 1);
      1: r.mprob = 17'd65536;
      default: r.mprob = 17'($urandom_range(0, 65536));
    endcase
    r.mdist = ($urandom_range(0, 1)) ? 16'(max_dist_reg + $urandom_range(0, 2) - 1)
                                     : 16'($urandom);
    return r;
  endfunction

  function automatic logic [63:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // extremes of every field, each classification path and the empty frame marker
  task automatic test_directed();
    report_t r;
    r = random_report(64'd0);
    r.command = CMD_REPORT; r.frame_start = 1; r.speed = 0; r.rcs = 0; r.jam = 0;
    r.status = ST_TENTATIVE; r.meas = 0; r.mstat = 0; r.mtype = 0; r.mprob = 0; r.mdist = 0;
    send_item(r);                                  // new key, decays from zero, unknown
    r.key = '1; r.speed = '1; r.rcs = '1; r.jam = 1; r.status = ST_CONFIRMED; r.meas = 1;
    r.frame_start = 0;
    send_item(r);                                  // top score, high threat by score
    send_item(r); send_item(r);                    // saturates at one
    r.status = ST_LOST; r.meas = 0;
    send_item(r);                                  // lost halves
    r.status = 2'd3;
    send_item(r);                                  // other status, no adjustment
    r.key = 64'h5555_aaaa_0f0f_f0f0; r.status = ST_CONFIRMED; r.speed = 1921; r.rcs = 308;
    r.jam = 0; r.mstat = MS_FOUND; r.mtype = CLS_HIGH_FIGHTER; r.mprob = 17'd65536;
    r.mdist = 460; r.meas = 1;
    send_item(r);                                  // accepted fighter match
    r.mdist = 461;
    send_item(r);                                  // distance just out
    r.mdist = 0; r.mprob = 36044;
    send_item(r);                                  // probability just short
    r.mprob = 36045; r.mstat = 2'd2;
    send_item(r);                                  // non-finite match
    r.mstat = 2'd3;
    send_item(r);                                  // unused match status
    r.mstat = MS_FOUND; r.mtype = 8'hff;
    send_item(r);                                  // accepted odd match type
    r.mtype = 0;
    send_item(r);                                  // zero type never accepted
    r.command = 1; r.frame_start = 0;
    send_item(r);                                  // empty frame keeps flags
    r.frame_start = 1;
    send_item(r);                                  // empty frame clears flags
    r.command = CMD_REPORT; r.frame_start = 0; r.speed = 4800; r.rcs = 768;
    r.status = ST_TENTATIVE; r.meas = 0; r.jam = 1; r.mstat = 0;
    send_item(r);                                  // tentative ceiling, boundary values
    r.speed = 4801; r.rcs = 767; r.meas = 1;
    send_item(r);
  endtask

  task automatic test_random_pool(int count);
    for (int i = 0; i < count; i++) begin
      if (key_pool.size() < 30 && $urandom_range(0, 2) == 0) key_pool.push_back(random_key());
      if (key_pool.size() == 0) key_pool.push_back(random_key());
      send_item(random_report(key_pool[$urandom_range(0, key_pool.size() - 1)]));
    end
  endtask

  // fill the table past its size, then mix stored and fresh keys
  task automatic test_table_overflow(int count);
    for (int i = 0; i < 70; i++) begin
      report_t r;
      r = random_report(random_key());
      r.command = CMD_REPORT;
      send_item(r);
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) send_item(random_report(random_key()));
      else send_item(random_report(key_pool[$urandom_range(0, key_pool.size() - 1)]));
    end
  endtask

  // receiver stalls in random stretches, with long runs of no stall
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 11) == 0) stall_left <= $urandom_range(1, 25);
    end
  end

  // result check: pop and empty are steady at the falling edge
  always @(negedge clk) begin
    if (rst_n && pop && !empty) begin
      res_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item, class %0d", out_class_code);
      end else begin
        e = expected_results.pop_front();
        if (out_class_code !== e.class_code || out_threat_level !== e.threat_level ||
            out_confidence !== e.confidence ||
            out_aggressive_allowed !== e.aggressive_allowed ||
            out_reduce_power !== e.reduce_power || out_jamming_signal !== e.jamming_signal ||
            out_recon_platform !== e.recon_platform ||
            out_table_overflow !== e.table_overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected cls %0d score %0d conf %0d aggr %0b flags %b ovf %0b,",
                     e.class_code, e.threat_level, e.confidence, e.aggressive_allowed,
                     {e.reduce_power, e.jamming_signal, e.recon_platform}, e.table_overflow,
                     " got cls %0d score %0d conf %0d aggr %0b flags %b ovf %0b",
                     out_class_code, out_threat_level, out_confidence,
                     out_aggressive_allowed,
                     {out_reduce_power, out_jamming_signal, out_recon_platform},
                     out_table_overflow);
        end
      end
    end
  end

  // watchdog: counts cycles with work pending and no handshake
  always @(negedge clk) begin
    if ((push && !full) || (pop && !empty) || (expected_results.size() == 0 && !push))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TRACK_SLOTS; i++) track_used[i] = 1'b0;
    {flag_reduce, flag_jam, flag_recon} = 3'b000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    drain();
    // loosest limits
    write_reg(CFG_MIN_PROB, 17'd0);
    write_reg(CFG_MAX_DIST, 17'h0ffff);
    write_reg(CFG_AGGR_CONF, 17'd0);
    write_reg(2'd3, 17'h1ffff);                    // unused index, ignored
    test_random_pool(120);
    drain();
    // strictest limits
    write_reg(CFG_MIN_PROB, 17'd65536);
    write_reg(CFG_MAX_DIST, 17'd0);
    write_reg(CFG_AGGR_CONF, 17'd65536);
    test_random_pool(120);
    drain();
    // mid settings
    write_reg(CFG_MIN_PROB, 17'd30000);
    write_reg(CFG_MAX_DIST, 17'd2000);
    write_reg(CFG_AGGR_CONF, 17'd40000);
    test_table_overflow(200);
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
